>>> hw/rtl/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg: shared types and constants of the fault code store
// Item layouts, controller states and the control group that the sequencer
// hands to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcs_pkg;

  localparam logic        OpSet      = 1'b0;
  localparam logic        OpRead     = 1'b1;
  localparam logic [31:0] CodeMask24 = 32'h00FF_FFFF;
  localparam logic [31:0] CodeErased = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        opcode;
    logic [31:0] fault_code;
    logic [7:0]  status_byte;
    logic        snapshot_present;
    logic [63:0] snapshot_data;
    logic [7:0]  slot_select;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot_used;
    logic [31:0] record_code;
    logic [7:0]  record_status;
    logic [63:0] record_snapshot;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic scan;
    logic finish;
  } fcs_ctrl_t;

endpackage

>>> hw/rtl/fcs_cell.sv
// ----------------------------------------------------------------------------
// fcs_cell: one slot of the record ring
// Holds one fault record; takes its neighbor's record on a shift and a new
// record on a write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcs_cell
  import fcs_pkg::*;
#(
  parameter int unsigned SnapBits = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                wr_i,
  input  logic [31:0]         nb_code_i,
  input  logic [7:0]          nb_status_i,
  input  logic [SnapBits-1:0] nb_snap_i,
  input  logic [31:0]         wr_code_i,
  input  logic [7:0]          wr_status_i,
  input  logic [SnapBits-1:0] wr_snap_i,
  output logic [31:0]         code_o,
  output logic [7:0]          status_o,
  output logic [SnapBits-1:0] snap_o
);

  logic [31:0]         code_q, code_d;
  logic [7:0]          status_q, status_d;
  logic [SnapBits-1:0] snap_q, snap_d;

  always_comb begin
    code_d   = code_q;
    status_d = status_q;
    snap_d   = snap_q;
    priority if (wr_i) begin
      code_d   = wr_code_i;
      status_d = wr_status_i;
      snap_d   = wr_snap_i;
    end else if (shift_i) begin
      code_d   = nb_code_i;
      status_d = nb_status_i;
      snap_d   = nb_snap_i;
    end
  end

  // reset to the erased record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q   <= CodeErased;
      status_q <= '0;
      snap_q   <= '0;
    end else begin
      code_q   <= code_d;
      status_q <= status_d;
      snap_q   <= snap_d;
    end
  end

  assign code_o   = code_q;
  assign status_o = status_q;
  assign snap_o   = snap_q;

endmodule

>>> hw/rtl/fcs_ctrl.sv
// ----------------------------------------------------------------------------
// fcs_ctrl: sequencer of the fault code store
// Runs one full ring rotation per item, none for a read out of range, and holds
// the finish step until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcs_ctrl
  import fcs_pkg::*;
#(
  parameter int unsigned SlotCount = 16,
  parameter int unsigned IdxW      = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            skip_scan_i,
  input  logic            out_free_i,
  output fcs_ctrl_t       ctrl_o,
  output logic [IdxW-1:0] step_o
);

  localparam logic [IdxW-1:0] LastStep = IdxW'(SlotCount - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] step_q, step_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = skip_scan_i ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step_q == LastStep) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    step_d = step_q;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        step_d          = '0;
      end
      ST_SCAN: begin
        ctrl_o.scan = 1'b1;
        step_d      = IdxW'(step_q + 1'b1);
      end
      ST_FINISH: begin
        ctrl_o.finish = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign step_o = step_q;

endmodule

>>> hw/rtl/fault_code_store.sv
// ----------------------------------------------------------------------------
// fault_code_store: table of fault records with round-robin replacement
// Each result is built after one full rotation of the record ring; a read out of
// range skips the rotation. A new item is taken only once the last one has left
// the sequencer, and it is taken while a result still waits in the output
// register.
// Reset: asynchronous, active low; every slot erased, pointer at slot zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fault_code_store
  import fcs_pkg::*;
#(
  parameter int unsigned SLOT_COUNT    = 16,
  parameter int unsigned SNAPSHOT_BITS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(SLOT_COUNT - 1);

  // Ring of cells: every scan cycle each cell takes the record of the next one
  // up, so cell zero shows slot <step> and after one full rotation every
  // record is home again.
  logic [31:0]              cell_code   [SLOT_COUNT];
  logic [7:0]               cell_status [SLOT_COUNT];
  logic [SNAPSHOT_BITS-1:0] cell_snap   [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]    cell_wr;

  fcs_ctrl_t       ctrl;
  logic [IdxW-1:0] step;
  logic            in_fire;
  logic            out_free;
  logic            rd_oor;

  // latched request
  in_item_t         req_q;
  logic             oor_q;
  // scan results
  logic             match_hit_q, match_hit_d;
  logic [IdxW-1:0]  match_idx_q, match_idx_d;
  logic             erased_hit_q, erased_hit_d;
  logic [IdxW-1:0]  erased_idx_q, erased_idx_d;
  logic [31:0]      cap_code_q;
  logic [7:0]       cap_status_q;
  logic [SNAPSHOT_BITS-1:0] cap_snap_q;
  // replacement pointer
  logic [IdxW-1:0]  ptr_q, ptr_d;
  // write side
  logic [IdxW-1:0]  wr_slot;
  logic             do_write;
  logic [SNAPSHOT_BITS-1:0] wr_snap;
  // output register
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic head_match;
  logic head_erased;
  logic [IdxW-1:0] sel_idx;

  assign in_fire  = in_valid_i && ctrl.in_ready;
  assign out_free = !out_valid_q || out_ready_i;
  assign rd_oor   = (in_item_i.opcode == OpRead) &&
                    ({1'b0, in_item_i.slot_select} >= 9'(SLOT_COUNT));
  assign sel_idx  = req_q.slot_select[IdxW-1:0];

  fcs_ctrl #(
    .SlotCount (SLOT_COUNT),
    .IdxW      (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .skip_scan_i (rd_oor),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl),
    .step_o      (step)
  );

  assign wr_snap = req_q.snapshot_present ? req_q.snapshot_data[SNAPSHOT_BITS-1:0] : '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    localparam int unsigned Nb = (i + 1) % SLOT_COUNT;

    assign cell_wr[i] = do_write && (wr_slot == IdxW'(i));

    fcs_cell #(
      .SnapBits (SNAPSHOT_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (ctrl.scan),
      .wr_i        (cell_wr[i]),
      .nb_code_i   (cell_code[Nb]),
      .nb_status_i (cell_status[Nb]),
      .nb_snap_i   (cell_snap[Nb]),
      .wr_code_i   (req_q.fault_code),
      .wr_status_i (req_q.status_byte),
      .wr_snap_i   (wr_snap),
      .code_o      (cell_code[i]),
      .status_o    (cell_status[i]),
      .snap_o      (cell_snap[i])
    );
  end

  // Compare the head cell against the request; slots arrive in ascending
  // order, so the first hit is the lowest one.
  assign head_match  = (cell_code[0] & CodeMask24) == (req_q.fault_code & CodeMask24);
  assign head_erased = (cell_code[0] & CodeMask24) == CodeMask24;

  always_comb begin
    match_hit_d  = match_hit_q;
    match_idx_d  = match_idx_q;
    erased_hit_d = erased_hit_q;
    erased_idx_d = erased_idx_q;
    if (in_fire) begin
      match_hit_d  = 1'b0;
      erased_hit_d = 1'b0;
    end else if (ctrl.scan) begin
      if (!match_hit_q && head_match) begin
        match_hit_d = 1'b1;
        match_idx_d = step;
      end
      if (!erased_hit_q && head_erased) begin
        erased_hit_d = 1'b1;
        erased_idx_d = step;
      end
    end
  end

  // Pick the slot: matching code first, then an erased slot, then the pointer.
  always_comb begin
    priority if (match_hit_q) begin
      wr_slot = match_idx_q;
    end else if (erased_hit_q) begin
      wr_slot = erased_idx_q;
    end else begin
      wr_slot = ptr_q;
    end
  end

  assign do_write = ctrl.finish && (req_q.opcode == OpSet);

  // advance and wrap the pointer only when it was used
  always_comb begin
    ptr_d = ptr_q;
    if (do_write && !match_hit_q && !erased_hit_q) begin
      ptr_d = (ptr_q == LastSlot) ? '0 : IdxW'(ptr_q + 1'b1);
    end
  end

  // Build the result item.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.finish) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (req_q.opcode == OpSet) begin
        out_d.ok        = 1'b1;
        out_d.slot_used = 4'(wr_slot);
      end else if (!oor_q) begin
        out_d.ok              = (cap_code_q != CodeErased) && (cap_code_q != '0);
        out_d.slot_used       = 4'(sel_idx);
        out_d.record_code     = cap_code_q;
        out_d.record_status   = cap_status_q;
        out_d.record_snapshot = 64'(cap_snap_q);
      end
    end
  end

  // payload registers: hold request, capture the selected slot during the scan
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_item_i;
      oor_q <= rd_oor;
    end
    if (ctrl.scan && (step == sel_idx)) begin
      cap_code_q   <= cell_code[0];
      cap_status_q <= cell_status[0];
      cap_snap_q   <= cell_snap[0];
    end
    match_idx_q  <= match_idx_d;
    erased_idx_q <= erased_idx_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_hit_q  <= 1'b0;
      erased_hit_q <= 1'b0;
      ptr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      match_hit_q  <= match_hit_d;
      erased_hit_q <= erased_hit_d;
      ptr_q        <= ptr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> bench/tb_fault_code_store.sv
// ----------------------------------------------------------------------------
// tb_fault_code_store: self-checking bench for the fault record table
// Drives set and read items through the valid/ready input channel and
// predicts each record from a local copy of the table, its slot choice and
// the round-robin overwrite pointer. Every result is compared field by field
// in arrival order. Both channels idle at random, and one phase chokes the
// output so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fault_code_store;
  import fcs_pkg::*;

  localparam int SLOTS        = 16;
  localparam int SNAP_BITS    = 64;
  localparam int CODE_POOL    = 24;    // more live codes than slots: forces overwrites
  localparam int CHOKE_CYCLES = 300;   // receiver hold-off during the pressure phase
  localparam int STALL_LIMIT  = 3000;  // cycles with no item moving on either side
  localparam int TAIL_CYCLES  = 40;    // well past one item's full ring rotation

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // Local image of the record table.
  logic [31:0] tbl_code [SLOTS];
  logic [7:0]  tbl_status [SLOTS];
  logic [63:0] tbl_snap [SLOTS];
  int          rr_ptr;

  out_item_t   expected_records[$];
  logic [31:0] code_pool [CODE_POOL];
  int          fail_count;
  int          idle_cycles;
  bit          tx_steady;
  bit          rx_steady;
  bit          choke_req;

  fault_code_store #(
    .SLOT_COUNT   (SLOTS),
    .SNAPSHOT_BITS(SNAP_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Gap length: mostly none, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Apply one item to the table image and return the record it must produce.
  function automatic out_item_t predict_fault_record(in_item_t it);
    out_item_t   res;
    int          slot;
    logic [63:0] snap_mask;
    res = '0;
    slot = -1;
    snap_mask = {64{1'b1}} >> (64 - SNAP_BITS);
    if (it.opcode == OpSet) begin
      // Prefer a slot holding the same low 24 code bits.
      for (int s = 0; s < SLOTS; s++)
        if (slot < 0 && (tbl_code[s] & CodeMask24) == (it.fault_code & CodeMask24))
          slot = s;
      // Fall back to the lowest erased slot (low 24 bits all ones).
      for (int s = 0; s < SLOTS; s++)
        if (slot < 0 && (tbl_code[s] & CodeMask24) == (CodeErased & CodeMask24))
          slot = s;
      // Table full: take the slot under the pointer and advance it.
      if (slot < 0) begin
        if (rr_ptr >= SLOTS) rr_ptr = 0;
        slot = rr_ptr;
        rr_ptr++;
        if (rr_ptr >= SLOTS) rr_ptr = 0;
      end
      tbl_code[slot]   = it.fault_code;
      tbl_status[slot] = it.status_byte;
      tbl_snap[slot]   = it.snapshot_present ? (it.snapshot_data & snap_mask) : 64'h0;
      res.ok        = 1'b1;
      res.slot_used = 4'(slot);
    end else if (it.slot_select < SLOTS) begin
      res.ok = (tbl_code[it.slot_select] != CodeErased) &&
               (tbl_code[it.slot_select] != 32'h0);
      res.slot_used       = it.slot_select[3:0];
      res.record_code     = tbl_code[it.slot_select];
      res.record_status   = tbl_status[it.slot_select];
      res.record_snapshot = tbl_snap[it.slot_select];
    end
    return res;
  endfunction

  // Unused fields carry noise so that every input bit toggles.
  function automatic in_item_t set_item(logic [31:0] code, logic [7:0] status,
                                        logic present, logic [63:0] data);
    in_item_t it;
    it.opcode           = OpSet;
    it.fault_code       = code;
    it.status_byte      = status;
    it.snapshot_present = present;
    it.snapshot_data    = data;
    it.slot_select      = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(logic [7:0] sel);
    in_item_t it;
    it.opcode           = OpRead;
    it.fault_code       = $urandom;
    it.status_byte      = 8'($urandom);
    it.snapshot_present = 1'($urandom);
    it.snapshot_data    = {$urandom, $urandom};
    it.slot_select      = sel;
    return it;
  endfunction

  // Random traffic: codes mostly from a small pool so that updates, erased
  // slots and round-robin overwrites all occur often.
  function automatic in_item_t next_random_item();
    logic [31:0] code;
    int          r;
    if ($urandom_range(0, 99) < 45) begin
      if ($urandom_range(0, 6) == 0) return read_item(8'($urandom_range(SLOTS, 255)));
      return read_item(8'($urandom_range(0, SLOTS - 1)));
    end
    if ($urandom_range(0, 49) == 0) code_pool[$urandom_range(0, CODE_POOL - 1)] = $urandom;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      code = code_pool[$urandom_range(0, CODE_POOL - 1)];
      if (r < 30) code[31:24] = 8'($urandom);
    end else if (r < 75) begin
      code = $urandom;
    end else if (r < 82) begin
      code = {8'($urandom), 24'hFF_FFFF};
    end else if (r < 88) begin
      code = {8'($urandom), 24'h00_0000};
    end else if (r < 92) begin
      code = CodeErased;
    end else begin
      code = tbl_code[$urandom_range(0, SLOTS - 1)];
    end
    return set_item(code, 8'($urandom), 1'($urandom), {$urandom, $urandom});
  endfunction

  // Offer one item and hold it until accepted. Valid stays high when the
  // next item follows with no gap.
  task automatic send_item(in_item_t it);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Let the clock edge of the last handshake pass first so that its item is already queued.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_records.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: random stalls, a steady mode, and a long choke on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (choke_req) begin
        choke_req  = 1'b0;
        stall_left = CHOKE_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (rx_steady) begin
        out_ready_i <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_ready_i <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Check results, record accepted items and watch for a hang.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      // Check the result first: it always belongs to an earlier item.
      if (out_valid_o && out_ready_i) begin
        if (expected_records.size() == 0) begin
          $error("result arrived with no item outstanding");
          fail_count++;
        end else begin
          want = expected_records.pop_front();
          report_field("ok", want.ok, out_item_o.ok);
          report_field("slot_used", want.slot_used, out_item_o.slot_used);
          report_field("record_code", want.record_code, out_item_o.record_code);
          report_field("record_status", want.record_status, out_item_o.record_status);
          report_field("record_snapshot", want.record_snapshot, out_item_o.record_snapshot);
        end
      end
      if (in_valid_i && in_ready_o)
        expected_records.push_back(predict_fault_record(in_item_i));
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no item moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Erased table: in-range reads are inactive, out-of-range reads are empty.
  task automatic test_reset_contents();
    send_item(read_item(8'd0));
    send_item(read_item(8'(SLOTS - 1)));
    send_item(read_item(8'(SLOTS)));
    send_item(read_item(8'hFF));
    wait_drained();
  endtask

  // Slot choice: update by low 24 bits, codes that look erased, zero codes.
  task automatic test_slot_choice();
    send_item(set_item(32'h0000_0000, 8'hFF, 1'b1, {64{1'b1}}));  // slot 0
    send_item(read_item(8'd0));                                    // zero code: inactive
    send_item(set_item(32'hAB00_0000, 8'h00, 1'b0, {64{1'b1}}));  // same low bits, no snapshot
    send_item(read_item(8'd0));
    send_item(set_item(32'h12FF_FFFF, 8'h5A, 1'b1, 64'h0123_4567_89AB_CDEF));
    send_item(read_item(8'd1));                                    // active despite erased low bits
    send_item(set_item(32'h0000_0001, 8'hA5, 1'b1, 64'h8000_0000_0000_0001));
    send_item(read_item(8'd1));                                    // took the erased-looking slot
    send_item(set_item(CodeErased, 8'h3C, 1'b1, 64'hFEDC_BA98_7654_3210));
    send_item(read_item(8'd2));                                    // all-ones code: inactive
    send_item(read_item(8'd3));
    wait_drained();
  endtask

  // Choke the output while the sender keeps offering back to back.
  task automatic test_output_backpressure();
    tx_steady = 1'b1;
    choke_req = 1'b1;
    repeat (24) send_item(next_random_item());
    wait_drained();
    tx_steady = 1'b0;
  endtask

  task automatic test_mixed_traffic(int count, bit steady);
    tx_steady = steady;
    rx_steady = steady;
    repeat (count) send_item(next_random_item());
    wait_drained();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    fail_count  = 0;
    idle_cycles = 0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    choke_req   = 1'b0;
    rr_ptr      = 0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_code[s]   = CodeErased;
      tbl_status[s] = 8'h00;
      tbl_snap[s]   = 64'h0;
    end
    foreach (code_pool[i]) code_pool[i] = $urandom;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_contents();
    test_slot_choice();
    test_mixed_traffic(300, 1'b1);
    test_output_backpressure();
    test_mixed_traffic(700, 1'b0);

    // Let any stray result show up before closing.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_records.size() != 0) begin
      $error("%0d results never arrived", expected_records.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
